// File: sv/fenwick_prefix_max_tree_unit_defines.svh
// Assertion macros shared by the checker of the prefix-max tree unit
`ifndef FENWICK_PREFIX_MAX_TREE_UNIT_DEFINES_SVH
`define FENWICK_PREFIX_MAX_TREE_UNIT_DEFINES_SVH

// same-cycle implication, off while reset is high
`define FPMT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpmt assertion failed");

// next-cycle implication, off while reset is high
`define FPMT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpmt assertion failed");

// next-cycle implication, live through reset
`define FPMT_ASSERT_RST_NXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("fpmt assertion failed");

`endif

// File: sv/fpmt_pkg.sv
// Package: field widths, operation codes and control types of the prefix-max tree unit
package fpmt_pkg;

  localparam int MODE_W   = 2;
  localparam int POS_IN_W = 11;
  localparam int VAL_IN_W = 20;
  localparam int OUT_W    = 20;

  localparam int DEF_TREE_SIZE   = 1024;
  localparam int DEF_NUM_TREES   = 2;
  localparam int DEF_VALUE_WIDTH = 20;

  localparam logic [MODE_W-1:0] MODE_RAISE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  typedef struct packed {
    logic load;
    logic step;
    logic clr_step;
  } ctl_cmd_t;

  typedef struct packed {
    logic active;
    logic clr_last;
  } sts_t;

endpackage

// File: sv/fpmt_ctrl.sv
// Controller state machine of the prefix-max tree unit
module fpmt_ctrl import fpmt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  sts_t     sts,
  output ctl_cmd_t cmd,
  output logic     busy,
  output logic     done
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EV   = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR: begin
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = S_RD;
      end
      S_RD: begin
        state_next = sts.active ? S_EV : S_OUT;
      end
      S_EV: begin
        state_next = S_RD;
      end
      S_OUT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLR;
      end
    endcase
  end

  assign cmd.load     = (state == S_IDLE) && start;
  assign cmd.step     = (state == S_EV);
  assign cmd.clr_step = (state == S_CLR);
  assign busy         = (state != S_IDLE);
  assign done         = (state == S_OUT);

endmodule

// File: sv/fpmt_datapath.sv
// Datapath of the prefix-max tree unit: node store, walk index and running maximum
module fpmt_datapath import fpmt_pkg::*; #(
  parameter int TREE_SIZE   = DEF_TREE_SIZE,
  parameter int NUM_TREES   = DEF_NUM_TREES,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  ctl_cmd_t            cmd,
  output sts_t                sts,
  input  logic [MODE_W-1:0]   mode,
  input  logic                tree_select,
  input  logic [POS_IN_W-1:0] position,
  input  logic [VAL_IN_W-1:0] value,
  output logic [OUT_W-1:0]    max_value
);

  localparam int DEPTH = NUM_TREES * TREE_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int TSB   = $clog2(TREE_SIZE + 1);
  localparam int PB    = (TSB > POS_IN_W) ? TSB : POS_IN_W;
  localparam int PW    = PB + 1;
  localparam int VW    = VALUE_WIDTH;

  logic [VW-1:0] mem [DEPTH];

  logic [MODE_W-1:0] op;
  logic [PW-1:0]     pos;
  logic [AW-1:0]     base;
  logic [VW-1:0]     val;
  logic [VW-1:0]     best;
  logic [AW-1:0]     clr_cnt;
  logic [VW-1:0]     rdata;

  logic [PW-1:0] pos_in;
  logic [PW-1:0] pos_first;
  logic [PW-1:0] low_bit;
  logic [AW-1:0] addr;
  logic [VW-1:0] wdata;
  logic          we;
  logic          item_ok;

  assign pos_in  = PW'(position);
  assign item_ok = ((mode == MODE_RAISE) || (mode == MODE_QUERY) || (mode == MODE_CLEAR))
                   && (int'(tree_select) < NUM_TREES);

  always_comb begin
    pos_first = pos_in;
    if ((mode == MODE_QUERY) && (pos_in > PW'(TREE_SIZE))) pos_first = PW'(TREE_SIZE);
  end

  assign low_bit = pos & (~pos + PW'(1));
  assign addr    = base + AW'(pos - PW'(1));
  assign we      = cmd.step && (op != MODE_QUERY);
  assign wdata   = ((op == MODE_RAISE) && (rdata < val)) ? val :
                   (op == MODE_RAISE) ? rdata : '0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= mode;
      pos  <= item_ok ? pos_first : '0;
      base <= AW'(AW'(tree_select) * AW'(TREE_SIZE));
      val  <= VW'(value);
      best <= '0;
    end else if (cmd.step) begin
      if (op == MODE_QUERY) begin
        if (best < rdata) best <= rdata;
        pos <= pos - low_bit;
      end else begin
        pos <= pos + low_bit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_cnt] <= '0;
    end else if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[addr];
  end

  assign sts.active   = (pos != '0) && (pos <= PW'(TREE_SIZE));
  assign sts.clr_last = (clr_cnt == AW'(DEPTH - 1));
  assign max_value    = OUT_W'(best);

endmodule

// File: sv/fenwick_prefix_max_tree_unit.sv
// Top level of the prefix-max tree unit: controller and datapath
//
//   channel   handshake        payload
//   command   start / busy     mode, tree_select, position, value
//   result    done (strobe)    max_value
//
// One word is accepted at a time: busy stays high while it walks its n nodes
// (at most 11 for 1024 nodes), and each node is a registered read of the node
// memory and a write-back or compare.
// After reset busy stays high while the clearing pass zeroes the memory,
// all NUM_TREES*TREE_SIZE entries, one entry a cycle.
// done is high for exactly one cycle; the receiver cannot stall it.
module fenwick_prefix_max_tree_unit import fpmt_pkg::*; #(
  parameter int TREE_SIZE   = DEF_TREE_SIZE,
  parameter int NUM_TREES   = DEF_NUM_TREES,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [MODE_W-1:0]   mode,
  input  logic                tree_select,
  input  logic [POS_IN_W-1:0] position,
  input  logic [VAL_IN_W-1:0] value,
  output logic                done,
  output logic [OUT_W-1:0]    max_value
);

  ctl_cmd_t cmd;
  sts_t     sts;

  fpmt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  fpmt_datapath #(
    .TREE_SIZE   (TREE_SIZE),
    .NUM_TREES   (NUM_TREES),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .mode        (mode),
    .tree_select (tree_select),
    .position    (position),
    .value       (value),
    .max_value   (max_value)
  );

endmodule

// File: sv/fpmt_checker.sv
// Port-level checker of the prefix-max tree unit and its bind
`include "fenwick_prefix_max_tree_unit_defines.svh"

module fpmt_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  `FPMT_ASSERT_RST_NXT(a_busy_after_rst, clk, rst, busy)
  `FPMT_ASSERT_IMP(a_done_while_busy, clk, rst, done, busy)
  `FPMT_ASSERT_NXT(a_idle_after_done, clk, rst, done, !busy && !done)
  `FPMT_ASSERT_NXT(a_busy_after_accept, clk, rst, start && !busy, busy && !done)

endmodule

bind fenwick_prefix_max_tree_unit fpmt_checker u_fpmt_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
